>>> src/rvalu_pkg.sv
package rvalu_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned DIV_STAGES = 16;

   typedef enum logic [2:0] {
      OP_ILLEGAL,
      OP_SIMPLE,
      OP_MUL,
      OP_DIV
   } op_class_type;

   localparam logic [6:0] F7_BASE = 7'd0;
   localparam logic [6:0] F7_ALT = 7'd32;
   localparam logic [6:0] F7_MD = 7'd1;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SLL = 3'd1;
   localparam logic [2:0] F3_SLT = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_SRL = 3'd5;
   localparam logic [2:0] F3_OR = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;

   localparam logic [2:0] F3_MUL = 3'd0;
   localparam logic [2:0] F3_MULH = 3'd1;
   localparam logic [2:0] F3_MULHSU = 3'd2;
   localparam logic [2:0] F3_MULHU = 3'd3;
   localparam logic [2:0] F3_DIV = 3'd4;
   localparam logic [2:0] F3_DIVU = 3'd5;
   localparam logic [2:0] F3_REM = 3'd6;
   localparam logic [2:0] F3_REMU = 3'd7;

   // decoded item between front and back
   typedef struct packed {
      op_class_type op_class;
      logic         alt;
      logic [2:0]   func3;
      logic [31:0]  a;
      logic [31:0]  b;
      logic [4:0]   dest;
   } item_type;

   // finished result
   typedef struct packed {
      logic [4:0]  dest;
      logic [31:0] value;
      logic        illegal;
   } result_type;

endpackage

>>> src/rvalu_front.sv
module rvalu_front #(
   parameter int unsigned Depth = rvalu_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [2:0]           req_func_low,
   input  logic [6:0]           req_func_high,
   input  logic [31:0]          req_first_operand,
   input  logic [31:0]          req_second_operand,
   input  logic [4:0]           req_dest_index,
   output logic                 item_valid,
   output rvalu_pkg::item_type  item,
   input  logic                 item_take
);
   import rvalu_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   item_type          mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   item_type          decoded;
   logic              do_push, do_pop;

   // classify encoding
   always_comb begin
      decoded.alt = (req_func_high == F7_ALT);
      decoded.func3 = req_func_low;
      decoded.a = req_first_operand;
      decoded.b = req_second_operand;
      decoded.dest = req_dest_index;
      priority if (req_func_high == F7_MD) begin
         decoded.op_class = req_func_low[2] ? OP_DIV : OP_MUL;
      end else if (req_func_high == F7_BASE) begin
         decoded.op_class = OP_SIMPLE;
      end else if (req_func_high == F7_ALT &&
                   (req_func_low == F3_ADD || req_func_low == F3_SRL)) begin
         decoded.op_class = OP_SIMPLE;
      end else begin
         decoded.op_class = OP_ILLEGAL;
      end
   end

   assign req_full = (count_ff == CntW'(Depth));
   assign do_push = req_push && !req_full;
   assign item_valid = (count_ff != '0);
   assign do_pop = item_valid && item_take;
   assign item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= decoded;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth)) else $error("queue count overflow");
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push lost");
   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop lost");
`endif

endmodule

>>> src/rvalu_back.sv
module rvalu_back #(
   parameter int unsigned DivStages = rvalu_pkg::DIV_STAGES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  rvalu_pkg::item_type    item,
   output logic                   item_take,
   output logic                   res_valid,
   output rvalu_pkg::result_type  res,
   input  logic                   res_take
);
   import rvalu_pkg::*;

   // pipeline length: stage 0 operand prep, DivStages divide steps, one fixup stage
   localparam int unsigned Lat = DivStages + 2;
   localparam int unsigned BitsPerStage = 32 / DivStages;
   localparam int unsigned SlotN = Lat + 2;
   localparam int unsigned SlotW = $clog2(SlotN + 1);

   // per-stage pipeline registers
   typedef struct packed {
      op_class_type op_class;
      logic [2:0]   func3;
      logic [4:0]   dest;
      logic [31:0]  value;
      logic         neg_q;
      logic         neg_r;
      logic         dzero;
      logic         ovf;
      logic [31:0]  a_orig;
      logic [31:0]  quot;
      logic [31:0]  rem;
      logic [31:0]  divisor;
      logic [31:0]  mul_lo;
      logic [31:0]  mul_mid;
   } stage_type;

   logic      vld_ff [Lat];
   stage_type stg_ff [Lat];
   stage_type stg_in [Lat];
   logic      advance;

   // output queue with room for every item in flight plus the one being popped
   result_type          oq_ff [SlotN];
   logic [SlotW-1:0]    oq_cnt_ff, oq_cnt_in, inflight;
   logic [SlotW-1:0]    oq_wr_ff, oq_rd_ff;
   logic                oq_push, oq_pop;

   always_comb begin
      inflight = '0;
      for (int i = 0; i < Lat; i++) begin
         inflight = inflight + SlotW'(vld_ff[i]);
      end
   end

   assign advance = 1'b1;
   assign item_take = item_valid && ((oq_cnt_ff + inflight) < SlotW'(SlotN));

   // stage 0: simple ops finish, mul partial products, div operand magnitudes
   logic [63:0] pp_lo, pp_hi;
   logic        sa, sb;
   logic [31:0] ma, mb;
   always_comb begin
      stg_in[0] = '0;
      stg_in[0].op_class = item.op_class;
      stg_in[0].func3 = item.func3;
      stg_in[0].dest = item.dest;
      stg_in[0].a_orig = item.a;
      sa = 1'b0;
      sb = 1'b0;
      unique case (item.func3)
         F3_MULH: begin sa = item.a[31]; sb = item.b[31]; end
         F3_MULHSU: begin sa = item.a[31]; end
         F3_DIV, F3_REM: begin sa = item.a[31]; sb = item.b[31]; end
         default: ;
      endcase
      ma = sa ? -item.a : item.a;
      mb = sb ? -item.b : item.b;
      pp_lo = 64'(ma) * 64'(mb[15:0]);
      pp_hi = 64'(ma) * 64'(mb[31:16]);
      unique case (item.op_class)
         OP_SIMPLE: begin
            unique case (item.func3)
               F3_ADD: stg_in[0].value = item.alt ? item.a - item.b : item.a + item.b;
               F3_SLL: stg_in[0].value = item.a << item.b[4:0];
               F3_SLT: stg_in[0].value = {31'd0, $signed(item.a) < $signed(item.b)};
               F3_SLTU: stg_in[0].value = {31'd0, item.a < item.b};
               F3_XOR: stg_in[0].value = item.a ^ item.b;
               F3_SRL: stg_in[0].value = item.alt ?
                  32'($signed(item.a) >>> item.b[4:0]) : item.a >> item.b[4:0];
               F3_OR: stg_in[0].value = item.a | item.b;
               F3_AND: stg_in[0].value = item.a & item.b;
               default: stg_in[0].value = '0;
            endcase
         end
         OP_MUL: begin
            stg_in[0].neg_q = sa ^ sb;
            stg_in[0].mul_lo = pp_lo[31:0];
            stg_in[0].quot = pp_lo[63:32];
            stg_in[0].mul_mid = pp_hi[31:0];
            stg_in[0].rem = pp_hi[63:32];
         end
         OP_DIV: begin
            stg_in[0].dzero = (item.b == '0);
            stg_in[0].ovf = (item.func3 == F3_DIV || item.func3 == F3_REM) &&
                            item.a == 32'h8000_0000 && item.b == 32'hFFFF_FFFF;
            stg_in[0].neg_q = sa ^ sb;
            stg_in[0].neg_r = sa;
            stg_in[0].quot = ma;
            stg_in[0].rem = '0;
            stg_in[0].divisor = mb;
         end
         default: ;
      endcase
   end

   // divide steps: restoring, BitsPerStage bits a stage; mul sum in first step
   logic [63:0] prod_full, prod_neg;
   generate
      for (genvar s = 1; s <= DivStages; s++) begin : g_step
         logic [32:0] r_w [BitsPerStage + 1];
         logic [31:0] q_w [BitsPerStage + 1];
         logic [32:0] diff;
         always_comb begin
            r_w[0] = {1'b0, stg_ff[s-1].rem};
            q_w[0] = stg_ff[s-1].quot;
            for (int k = 0; k < BitsPerStage; k++) begin
               r_w[k+1] = {r_w[k][31:0], q_w[k][31]};
               q_w[k+1] = {q_w[k][30:0], 1'b0};
               diff = r_w[k+1] - {1'b0, stg_ff[s-1].divisor};
               if (!diff[32]) begin
                  r_w[k+1] = diff;
                  q_w[k+1][0] = 1'b1;
               end
            end
            stg_in[s] = stg_ff[s-1];
            if (stg_ff[s-1].op_class == OP_DIV) begin
               stg_in[s].quot = q_w[BitsPerStage];
               stg_in[s].rem = r_w[BitsPerStage][31:0];
            end
            // product lands in stage 1 as mul_lo / mul_mid (low / high word)
            if (s == 1 && stg_ff[0].op_class == OP_MUL) begin
               stg_in[s].mul_lo = prod_full[31:0];
               stg_in[s].mul_mid = stg_ff[0].neg_q ? prod_neg[63:32] : prod_full[63:32];
            end
         end
      end
   endgenerate

   // first stage after prep combines the two partial products
   always_comb begin
      prod_full = {stg_ff[0].quot, stg_ff[0].mul_lo} +
                  {stg_ff[0].rem[15:0], stg_ff[0].mul_mid, 16'd0};
      prod_neg = -prod_full;
   end

   // fixup stage
   always_comb begin
      stg_in[Lat-1] = stg_ff[Lat-2];
      unique case (stg_ff[Lat-2].op_class)
         OP_MUL: begin
            unique case (stg_ff[Lat-2].func3)
               F3_MUL: stg_in[Lat-1].value = stg_ff[Lat-2].mul_lo;
               default: stg_in[Lat-1].value = stg_ff[Lat-2].mul_mid;
            endcase
         end
         OP_DIV: begin
            priority if (stg_ff[Lat-2].dzero) begin
               stg_in[Lat-1].value = stg_ff[Lat-2].func3[1] ?
                  stg_ff[Lat-2].a_orig : 32'hFFFF_FFFF;
            end else if (stg_ff[Lat-2].ovf) begin
               stg_in[Lat-1].value = stg_ff[Lat-2].func3[1] ? 32'd0 : 32'h8000_0000;
            end else if (stg_ff[Lat-2].func3[1]) begin
               stg_in[Lat-1].value = stg_ff[Lat-2].neg_r ?
                  -stg_ff[Lat-2].rem : stg_ff[Lat-2].rem;
            end else begin
               stg_in[Lat-1].value = stg_ff[Lat-2].neg_q ?
                  -stg_ff[Lat-2].quot : stg_ff[Lat-2].quot;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= item_take;
         for (int i = 1; i < Lat; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      stg_ff[0] <= stg_in[0];
      for (int i = 2; i < Lat - 1; i++) begin
         stg_ff[i] <= stg_in[i];
      end
      stg_ff[1] <= stg_in[1];
      stg_ff[Lat-1] <= stg_in[Lat-1];
   end

   // output queue
   result_type done;
   always_comb begin
      done.dest = stg_ff[Lat-1].dest;
      done.illegal = (stg_ff[Lat-1].op_class == OP_ILLEGAL);
      done.value = done.illegal ? '0 : stg_ff[Lat-1].value;
   end

   assign oq_push = vld_ff[Lat-1] && advance;
   assign res_valid = (oq_cnt_ff != '0);
   assign oq_pop = res_valid && res_take;
   assign res = oq_ff[oq_rd_ff];

   always_comb begin
      oq_cnt_in = oq_cnt_ff;
      if (oq_push && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (oq_pop && !oq_push) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_cnt_ff <= '0;
         oq_wr_ff <= '0;
         oq_rd_ff <= '0;
      end else begin
         oq_cnt_ff <= oq_cnt_in;
         if (oq_push) begin
            oq_wr_ff <= (oq_wr_ff == SlotW'(SlotN - 1)) ? '0 : oq_wr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ff <= (oq_rd_ff == SlotW'(SlotN - 1)) ? '0 : oq_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= done;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (oq_cnt_ff + inflight) <= SlotW'(SlotN)) else $error("result slots overrun");
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      oq_push |-> (oq_cnt_ff < SlotW'(SlotN)) || oq_pop) else $error("result queue overflow");
   a_take_enters: assert property (@(posedge clock) disable iff (reset)
      item_take |=> vld_ff[0]) else $error("item dropped at entry");
`endif

endmodule

>>> src/rv32im_register_alu.sv
// rv32im register-register execute unit. instructions enter through a queue-style
// push/full port and results leave through empty/pop in issue order. a front queue
// holds decoded instructions; the back is a fixed-latency pipeline (operand prep
// and multiply partial products, one radix step group per stage of the restoring
// divider, then a fixup stage for sign, divide by zero and overflow). every
// instruction class takes the same path, so one transfer per cycle is sustained
// while the result queue has room. a result queue sized to the pipeline lets the
// back keep accepting while results wait to be popped.
module rv32im_register_alu #(
   parameter int unsigned QueueDepth = rvalu_pkg::QUEUE_DEPTH,
   parameter int unsigned DivStages = rvalu_pkg::DIV_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_func_low,
   input  logic [6:0]  req_func_high,
   input  logic [31:0] req_first_operand,
   input  logic [31:0] req_second_operand,
   input  logic [4:0]  req_dest_index,
   output logic        empty,
   input  logic        pop,
   output logic [4:0]  rsp_write_index,
   output logic [31:0] rsp_result_value,
   output logic        rsp_write_enable,
   output logic        rsp_illegal
);
   import rvalu_pkg::*;

   // decoded instruction handoff from front to back
   logic       item_valid, item_take;
   item_type   item;
   // completed result at head of output queue
   logic       res_valid;
   result_type res;

   rvalu_front #(.Depth(QueueDepth)) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (push),
      .req_full           (full),
      .req_func_low       (req_func_low),
      .req_func_high      (req_func_high),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .req_dest_index     (req_dest_index),
      .item_valid         (item_valid),
      .item               (item),
      .item_take          (item_take)
   );

   rvalu_back #(.DivStages(DivStages)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .res_valid  (res_valid),
      .res        (res),
      .res_take   (pop)
   );

   // illegal encodings still pass the destination through
   assign empty = !res_valid;
   assign rsp_write_index = res.dest;
   assign rsp_result_value = res.value;
   assign rsp_illegal = res.illegal;
   assign rsp_write_enable = !res.illegal;

`ifndef NO_ASSERTIONS
   a_we_excl: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_write_enable != rsp_illegal)) else $error("enable and illegal clash");
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_illegal) |-> rsp_result_value == '0) else $error("illegal value nonzero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty) else $error("result vanished");
`endif

endmodule
